/* hdl/tst_pkg.sv */
package tst_pkg;

   localparam int unsigned SPEED_W = 8;
   localparam int unsigned CSR_ADDR_W = 3;
   localparam int unsigned CSR_DATA_W = 32;

   typedef logic [SPEED_W-1:0] speed_type;

   localparam speed_type FLOOR_RESET = 8'd50;
   localparam speed_type CEIL_RESET  = 8'd200;

   // register index, taken from paddr[2]
   typedef enum logic {
      REG_FLOOR = 1'b0,
      REG_CEIL  = 1'b1
   } reg_index_type;

   // acceleration step: ceiling / 100, which is 0, 1 or 2 for an 8-bit value
   localparam speed_type STEP_ONE_THRESH = 8'd100;
   localparam speed_type STEP_TWO_THRESH = 8'd200;

   function automatic speed_type step_of(input speed_type ceil_spd);
      speed_type step;
      step = 8'd0;
      if (ceil_spd >= STEP_TWO_THRESH) begin
         step = 8'd2;
      end else if (ceil_spd >= STEP_ONE_THRESH) begin
         step = 8'd1;
      end
      return step;
   endfunction

   // tiered decay; each tier tests the speed left by the one before it
   function automatic speed_type decay_of(input speed_type cur, input speed_type floor_spd,
                                          input speed_type ceil_spd);
      speed_type s1;
      speed_type s2;
      speed_type s3;
      speed_type half;
      speed_type three_q;
      half    = ceil_spd >> 1;
      three_q = SPEED_W'({2'b00, ceil_spd[SPEED_W-1:2]} * 8'd3);
      s1 = (cur > floor_spd) ? cur - 8'd1 : cur;
      s2 = (s1 > half) ? s1 - 8'd1 : s1;
      if (s2 > three_q) begin
         s3 = (s2 > 8'd2) ? s2 - 8'd2 : 8'd0;
      end else begin
         s3 = s2;
      end
      return s3;
   endfunction

endpackage

/* hdl/tst_req_if.sv */
interface tst_req_if;
   logic valid;
   logic ready;
   logic mode;
   logic key_pressed;
   logic is_toggle_key;

   modport source (output valid, output mode, output key_pressed, output is_toggle_key,
                   input ready);
   modport sink (input valid, input mode, input key_pressed, input is_toggle_key,
                 output ready);
endinterface

interface tst_rsp_if;
   logic valid;
   logic ready;
   logic [7:0] speed;
   logic active;

   modport source (output valid, output speed, output active, input ready);
   modport sink (input valid, input speed, input active, output ready);
endinterface

/* hdl/typing_rate_speed_tracker.sv */
// Typing-rate speed tracker.
// req_bus carries one beat per key event (mode 0, with key_pressed and
// is_toggle_key) or per millisecond tick (mode 1). rsp_bus returns exactly one
// beat per request: the animation speed and the tracking-enable flag after it.
// The APB port holds the speed floor at byte address 0 and the speed ceiling
// at address 4; write them only while no request is in flight. pready is tied high.
// An accepted request is held in an input register, which feeds a single update
// stage whose state registers are the response register. One request is taken
// every cycle while rsp_bus takes each response.
// When rsp_bus stalls, the response holds, the input register fills, and
// req_bus.ready drops only once both stages are full.
// Synchronous reset empties both stages, loads floor 50, ceiling 200,
// speed 50, disables tracking and clears the decay counter and first-decay flag.
// Decay fires on the first enabled tick and then once more than
// DECAY_PERIOD_MS ticks have passed since the last decay.
module typing_rate_speed_tracker #(
   parameter int unsigned DECAY_PERIOD_MS = 500
) (
   input  logic clock,
   input  logic reset,
   tst_req_if.sink req_bus,
   tst_rsp_if.source rsp_bus,
   input  logic psel,
   input  logic penable,
   input  logic pwrite,
   input  logic [tst_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [tst_pkg::CSR_DATA_W-1:0] pwdata,
   output logic [tst_pkg::CSR_DATA_W-1:0] prdata,
   output logic pready
);
   import tst_pkg::*;

   localparam int unsigned CNT_W = $clog2(DECAY_PERIOD_MS + 2);
   localparam logic [CNT_W-1:0] PERIOD_C = CNT_W'(DECAY_PERIOD_MS);

   // configuration
   speed_type min_ff, max_ff;
   reg_index_type reg_sel;
   logic csr_wr;

   assign pready  = 1'b1;
   assign reg_sel = reg_index_type'(paddr[2]);
   assign csr_wr  = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         min_ff <= FLOOR_RESET;
         max_ff <= CEIL_RESET;
      end else if (csr_wr) begin
         unique case (reg_sel)
            REG_FLOOR: min_ff <= pwdata[SPEED_W-1:0];
            REG_CEIL:  max_ff <= pwdata[SPEED_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      prdata = '0;
      unique case (reg_sel)
         REG_FLOOR: prdata = CSR_DATA_W'(min_ff);
         REG_CEIL:  prdata = CSR_DATA_W'(max_ff);
         default: prdata = '0;
      endcase
   end

   // input register
   logic in_valid_ff;
   logic mode_ff, pressed_ff, toggle_ff;
   logic out_valid_ff;
   logic out_free, advance;

   assign out_free      = !out_valid_ff || rsp_bus.ready;
   assign advance       = in_valid_ff && out_free;
   assign req_bus.ready = !in_valid_ff || out_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_bus.ready) begin
         in_valid_ff <= req_bus.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_bus.valid && req_bus.ready) begin
         mode_ff    <= req_bus.mode;
         pressed_ff <= req_bus.key_pressed;
         toggle_ff  <= req_bus.is_toggle_key;
      end
   end

   // tracker state, doubles as the response register
   speed_type speed_ff, speed_in;
   logic on_ff, on_in;
   logic [CNT_W-1:0] ms_ff, ms_in, ms_inc;
   logic decayed_ff, decayed_in;
   logic [SPEED_W:0] acc_sum;
   speed_type acc_speed;
   logic fire;

   always_comb begin
      acc_sum   = {1'b0, speed_ff} + {1'b0, step_of(max_ff)};
      acc_speed = speed_ff;
      if (on_ff && (speed_ff < max_ff)) begin
         acc_speed = acc_sum[SPEED_W] ? '1 : acc_sum[SPEED_W-1:0];
      end
      ms_inc = (ms_ff <= PERIOD_C) ? ms_ff + 1'b1 : ms_ff;
      fire   = on_ff && ((ms_inc > PERIOD_C) || !decayed_ff);

      speed_in   = speed_ff;
      on_in      = on_ff;
      ms_in      = ms_ff;
      decayed_in = decayed_ff;
      if (!mode_ff) begin
         if (pressed_ff) begin
            speed_in = acc_speed;
            if (toggle_ff) begin
               on_in = !on_ff;
               if (on_ff) begin
                  speed_in = min_ff;
               end
            end
         end
      end else begin
         ms_in = ms_inc;
         if (fire) begin
            speed_in   = decay_of(speed_ff, min_ff, max_ff);
            ms_in      = '0;
            decayed_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         speed_ff     <= FLOOR_RESET;
         on_ff        <= 1'b0;
         ms_ff        <= '0;
         decayed_ff   <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (advance) begin
            speed_ff   <= speed_in;
            on_ff      <= on_in;
            ms_ff      <= ms_in;
            decayed_ff <= decayed_in;
         end
         if (out_free) begin
            out_valid_ff <= in_valid_ff;
         end
      end
   end

   assign rsp_bus.valid  = out_valid_ff;
   assign rsp_bus.speed  = speed_ff;
   assign rsp_bus.active = on_ff;

   // checks
   a_cnt_sat: assert property (@(posedge clock) disable iff (reset)
      ms_ff <= PERIOD_C + 1'b1)
      else $error("decay counter passed its saturation value");

   a_disable_min: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && $fell(on_ff)) |-> speed_ff == $past(min_ff))
      else $error("speed not at floor after disable");

   a_decayed_sticky: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> !$fell(decayed_ff))
      else $error("first-decay flag cleared outside reset");

   a_state_hold: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !rsp_bus.ready) |=> $stable(speed_ff) && $stable(on_ff))
      else $error("tracker state moved while response stalled");

   a_in_hold: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !out_free) |=> in_valid_ff && $stable(mode_ff)
                                      && $stable(pressed_ff) && $stable(toggle_ff))
      else $error("input register lost a held beat");

endmodule
